>>> rtl/gbfp_pkg.sv
// Shared types, constants and helpers for the binary frame parser.
package gbfp_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 1024;
  localparam int unsigned NUM_KINDS_DEF   = 8;

  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned QDEPTH   = 4;

  localparam logic [7:0]  SYNC_FIRST    = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND   = 8'h62;
  localparam logic [10:0] FRAME_LEN_SAT = 11'd2047;

  typedef logic [DATA_W-1:0] kind_reg_t;

  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_CLASS   = 3'd2,
    PH_ID      = 3'd3,
    PH_LEN     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CKA     = 3'd6,
    PH_CKB     = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    EV_DATA     = 3'd0,
    EV_GOOD     = 3'd1,
    EV_CKA_BAD  = 3'd2,
    EV_CKB_BAD  = 3'd3,
    EV_TOO_LONG = 3'd4
  } ev_t;

  typedef struct packed {
    ev_t               event_res;
    logic [KIND_W-1:0] msg_kind;
    logic [9:0]        byte_offset;
    logic [7:0]        data_byte;
    logic [10:0]       frame_length;
  } result_t;

  function automatic logic [10:0] sat_len(input logic [15:0] len);
    logic [10:0] res;
    if (len > 16'(FRAME_LEN_SAT)) res = FRAME_LEN_SAT;
    else res = len[10:0];
    return res;
  endfunction

endpackage

>>> rtl/gbfp_regs.sv
// Message kind select registers behind the APB-style port.
module gbfp_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gbfp_pkg::ADDR_W-1:0]   paddr,
  input  logic [gbfp_pkg::DATA_W-1:0]   pwdata,
  output logic [gbfp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output gbfp_pkg::kind_reg_t           kind_sel_o [gbfp_pkg::NUM_REGS]
);
  import gbfp_pkg::*;

  kind_reg_t         kind_sel_r [NUM_REGS];
  logic [KIND_W-1:0] idx;
  logic              wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = kind_sel_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) kind_sel_r[i] <= '0;
    end else if (wr_en) begin
      kind_sel_r[idx] <= pwdata;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) kind_sel_o[i] = kind_sel_r[i];
  end

endmodule

>>> rtl/gbfp_front.sv
// Front end: frame state machine, kind match, length and checksum tracking.
module gbfp_front #(
  parameter int unsigned MAX_PAYLOAD = gbfp_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned NUM_KINDS   = gbfp_pkg::NUM_KINDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept_i,
  input  logic [7:0]           byte_i,
  input  gbfp_pkg::kind_reg_t  kind_sel_i [gbfp_pkg::NUM_REGS],
  output logic                 res_valid_o,
  output gbfp_pkg::result_t    res_o
);
  import gbfp_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);

  phase_t            state_r, state_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [7:0]        class_r, class_nxt;
  logic [7:0]        len_lo_r, len_lo_nxt;
  logic              len_hi_r, len_hi_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]        sum_a_r, sum_a_nxt;
  logic [7:0]        sum_b_r, sum_b_nxt;

  logic              hit;
  logic [KIND_W-1:0] hit_idx;
  logic [14:0]       forced;
  logic [15:0]       full_len;
  logic [LEN_W-1:0]  cnt_inc;

  // Lowest matching index wins: scan downward so the last hit sticks.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = NUM_KINDS - 1; i >= 0; i--) begin
      if (kind_sel_i[i][31] && kind_sel_i[i][7:0] == class_r &&
          kind_sel_i[i][15:8] == byte_i) begin
        hit     = 1'b1;
        hit_idx = KIND_W'(i);
      end
    end
  end

  assign forced  = kind_sel_i[kind_r][30:16];
  assign cnt_inc = cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= PH_HUNT1;
      kind_r   <= '0;
      class_r  <= '0;
      len_lo_r <= '0;
      len_hi_r <= 1'b0;
      len_r    <= '0;
      cnt_r    <= '0;
      sum_a_r  <= '0;
      sum_b_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      kind_r   <= kind_nxt;
      class_r  <= class_nxt;
      len_lo_r <= len_lo_nxt;
      len_hi_r <= len_hi_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      sum_a_r  <= sum_a_nxt;
      sum_b_r  <= sum_b_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    class_nxt   = class_r;
    len_lo_nxt  = len_lo_r;
    len_hi_nxt  = len_hi_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    sum_a_nxt   = sum_a_r;
    sum_b_nxt   = sum_b_r;
    full_len    = '0;
    res_valid_o = 1'b0;
    res_o.event_res    = EV_DATA;
    res_o.msg_kind     = kind_r;
    res_o.byte_offset  = '0;
    res_o.data_byte    = '0;
    res_o.frame_length = sat_len(16'(len_r));

    if (accept_i) begin
      unique case (state_r)
        PH_HUNT1: begin
          if (byte_i == SYNC_FIRST) state_nxt = PH_HUNT2;
        end
        PH_HUNT2: begin
          // A mismatching byte is not retried as a first sync byte.
          state_nxt = (byte_i == SYNC_SECOND) ? PH_CLASS : PH_HUNT1;
        end
        PH_CLASS: begin
          sum_a_nxt = byte_i;
          sum_b_nxt = byte_i;
          class_nxt = byte_i;
          state_nxt = PH_ID;
        end
        PH_ID: begin
          sum_a_nxt = sum_a_r + byte_i;
          sum_b_nxt = sum_b_r + sum_a_nxt;
          if (hit) begin
            kind_nxt   = hit_idx;
            len_hi_nxt = 1'b0;
            state_nxt  = PH_LEN;
          end else begin
            state_nxt = PH_HUNT1;
          end
        end
        PH_LEN: begin
          sum_a_nxt = sum_a_r + byte_i;
          sum_b_nxt = sum_b_r + sum_a_nxt;
          if (!len_hi_r) begin
            len_lo_nxt = byte_i;
            len_hi_nxt = 1'b1;
          end else begin
            len_hi_nxt = 1'b0;
            full_len   = (forced != '0) ? {1'b0, forced} : {byte_i, len_lo_r};
            cnt_nxt    = '0;
            if (full_len > 16'(MAX_PAYLOAD)) begin
              res_valid_o        = 1'b1;
              res_o.event_res    = EV_TOO_LONG;
              res_o.frame_length = sat_len(full_len);
              state_nxt          = PH_HUNT1;
            end else begin
              len_nxt   = LEN_W'(full_len);
              state_nxt = (full_len == '0) ? PH_CKA : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          sum_a_nxt         = sum_a_r + byte_i;
          sum_b_nxt         = sum_b_r + sum_a_nxt;
          cnt_nxt           = cnt_inc;
          res_valid_o       = 1'b1;
          res_o.byte_offset = 10'(cnt_r);
          res_o.data_byte   = byte_i;
          if (cnt_inc >= len_r) state_nxt = PH_CKA;
        end
        PH_CKA: begin
          if (byte_i != sum_a_r) begin
            res_valid_o     = 1'b1;
            res_o.event_res = EV_CKA_BAD;
            state_nxt       = PH_HUNT1;
          end else begin
            state_nxt = PH_CKB;
          end
        end
        PH_CKB: begin
          res_valid_o     = 1'b1;
          res_o.event_res = (byte_i == sum_b_r) ? EV_GOOD : EV_CKB_BAD;
          state_nxt       = PH_HUNT1;
        end
        default: state_nxt = PH_HUNT1;
      endcase
    end
  end

endmodule

>>> rtl/gbfp_fifo.sv
// Result queue between the front end and the result port.
module gbfp_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en_i,
  input  gbfp_pkg::result_t  wr_data_i,
  input  logic               rd_en_i,
  output gbfp_pkg::result_t  rd_data_o,
  output logic               full_o,
  output logic               empty_o
);
  import gbfp_pkg::*;

  localparam int unsigned PTR_W = $clog2(QDEPTH);
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  result_t          q_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full_o    = (count_r == CNT_W'(QDEPTH));
  assign empty_o   = (count_r == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) count_nxt = count_r + 1'b1;
    else if (do_rd && !do_wr) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) q_r[wr_ptr_r] <= wr_data_i;
  end

endmodule

>>> rtl/gnss_binary_frame_parser.sv
// Top level of the binary frame parser: registers, front end and result queue.
//
//  channel  direction  handshake              payload
//  input    in         push / full            in_rx_byte
//  result   out        empty / pop            out_event_res .. out_frame_length
//  config   in/out     psel penable pwrite    paddr pwdata prdata pready
//
// One byte is taken each cycle while full is low; the frame state machine in the
// front end updates once per byte taken and writes at most one result beat into a
// four-deep result queue, whose oldest unread result drives the out ports.
// full rises only when the queue holds four unread results; input stalls then.
// rst_n is synchronous; after reset the parser hunts for the first sync byte and
// all kind select registers read zero.
module gnss_binary_frame_parser #(
  parameter int unsigned MAX_PAYLOAD = gbfp_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned NUM_KINDS   = gbfp_pkg::NUM_KINDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_rx_byte,
  output logic                          empty,
  input  logic                          pop,
  output logic [2:0]                    out_event_res,
  output logic [2:0]                    out_msg_kind,
  output logic [9:0]                    out_byte_offset,
  output logic [7:0]                    out_data_byte,
  output logic [10:0]                   out_frame_length,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gbfp_pkg::ADDR_W-1:0]   paddr,
  input  logic [gbfp_pkg::DATA_W-1:0]   pwdata,
  output logic [gbfp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import gbfp_pkg::*;

  kind_reg_t kind_sel [NUM_REGS];
  logic      accept;
  logic      res_valid;
  result_t   res;
  result_t   head;

  assign accept = push && !full;

  gbfp_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .kind_sel_o (kind_sel)
  );

  gbfp_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .NUM_KINDS   (NUM_KINDS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept_i    (accept),
    .byte_i      (in_rx_byte),
    .kind_sel_i  (kind_sel),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  gbfp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en_i   (res_valid),
    .wr_data_i (res),
    .rd_en_i   (pop),
    .rd_data_o (head),
    .full_o    (full),
    .empty_o   (empty)
  );

  assign out_event_res    = head.event_res;
  assign out_msg_kind     = head.msg_kind;
  assign out_byte_offset  = head.byte_offset;
  assign out_data_byte    = head.data_byte;
  assign out_frame_length = head.frame_length;

endmodule
